// ----- rtl/nfst_pkg.sv -----
package nfst_pkg;

    // default window store depth
    localparam int DEF_HISTORY_DEPTH = 128;

    // field widths
    localparam int LEVEL_W  = 16;
    localparam int MULT_W   = 8;
    localparam int WLEN_W   = 8;
    localparam int THRESH_W = 20;
    localparam int VAR_W    = 32;
    localparam int ROOT_W   = 16;

    localparam logic [THRESH_W-1:0] THRESH_MAX = '1;
    localparam int MIN_WINDOW = 10;

    // widths that follow from the default depth
    localparam int DEF_COUNT_W    = $clog2(DEF_HISTORY_DEPTH + 1);
    localparam int DEF_DIVIDEND_W = 2 * (LEVEL_W + DEF_COUNT_W);
    localparam int DEF_DIVISOR_W  = 2 * DEF_COUNT_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONSET_MULTIPLIER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_MULTIPLIER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_FLOOR    = 2'd3;

    localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH      = 8'd86;
    localparam logic [MULT_W-1:0]  RST_ONSET_MULTIPLIER   = 8'd96;
    localparam logic [MULT_W-1:0]  RST_SILENCE_MULTIPLIER = 8'd32;
    localparam logic [LEVEL_W-1:0] RST_DEVIATION_FLOOR    = 16'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] chunk_level;
    } t_in_item;

    typedef struct packed {
        logic                ready_res;
        logic [LEVEL_W-1:0]  mean_level;
        logic [LEVEL_W-1:0]  deviation;
        logic [THRESH_W-1:0] onset_threshold;
        logic [THRESH_W-1:0] silence_threshold;
    } t_out_item;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ----- rtl/nfst_chan_if.sv -----
interface nfst_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/nfst_ram.sv -----
module nfst_ram #(
    parameter int WIDTH = nfst_pkg::LEVEL_W,
    parameter int DEPTH = nfst_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/nfst_div.sv -----
module nfst_div #(
    parameter int DIVIDEND_W = nfst_pkg::DEF_DIVIDEND_W,
    parameter int DIVISOR_W  = nfst_pkg::DEF_DIVISOR_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output nfst_pkg::t_unit_sts   o_sts
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0] w_shift;
    logic [DIVISOR_W:0] w_diff;
    logic               w_ge;

    // one quotient bit a cycle, restoring
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule

// ----- rtl/nfst_sqrt.sv -----
module nfst_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nfst_pkg::VAR_W-1:0]   i_radicand,
    output logic [nfst_pkg::ROOT_W-1:0]  o_root,
    output nfst_pkg::t_unit_sts          o_sts
);
    localparam int VW    = nfst_pkg::VAR_W;
    localparam int RW    = nfst_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_root;
    logic [VW-1:0]    r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [VW:0] w_trial;
    logic        w_ge;

    // one root bit a cycle, digit by digit
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign w_ge    = {1'b0, r_rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_radicand;
            r_root <= '0;
            r_bit  <= VW'(1) << (VW - 2);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem  <= r_rem - w_trial[VW-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root     = r_root[RW-1:0];
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule

// ----- rtl/noise_floor_sigma_tracker.sv -----
// noise floor tracker: each chunk level request is written into a circular window of
// window_length entries (clamped to 10..HISTORY_DEPTH) and, once two or more entries are
// held, the block sweeps the window once through its memory read port to build the sum and
// the sum of squares, then uses one iterative divider twice (mean, then population
// variance) and an iterative square root, clamps the deviation below by deviation_floor and
// forms the onset and silence thresholds as mean + k*deviation in Q4.4, saturated at 20 bits.
// one result leaves per request. the time an item takes grows with its n window entries
// and the divider width DW = 32 + 2*clog2(HISTORY_DEPTH + 1) (48 at the default depth);
// the window sweep and the bit-serial divider set it. with fewer than two entries the
// sweep, division and square root are skipped. the input is not ready while an item is
// in work; a finished result waits in the output register and the next request can be
// taken meanwhile. the window memory needs no clearing pass. the user must write
// configuration only while the block is idle; the block itself does not enforce this.
module noise_floor_sigma_tracker #(
    parameter int HISTORY_DEPTH = nfst_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    nfst_chan_if.sink                       i_in,
    nfst_chan_if.source                     o_out,
    input  logic                            i_cfg_we,
    input  logic [nfst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nfst_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int LW  = nfst_pkg::LEVEL_W;
    localparam int MW  = nfst_pkg::MULT_W;
    localparam int TW  = nfst_pkg::THRESH_W;
    localparam int TSW = TW + 1;
    localparam int AW  = $clog2(HISTORY_DEPTH);       // memory address
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);   // entry count
    localparam int SW  = LW + CW;                     // sum of levels
    localparam int QW  = 2 * LW + CW;                 // sum of squares
    localparam int NW  = 2 * SW;                      // n*Q and S*S
    localparam int DVW = 2 * CW;                      // n*n
    localparam int PW  = MW + LW;                     // multiplier times deviation

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIVM  = 4'd4;
    localparam logic [3:0] S_DIVV  = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_THR   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // configuration registers
    logic [nfst_pkg::WLEN_W-1:0] r_window_length;
    logic [MW-1:0]               r_onset_mult;
    logic [MW-1:0]               r_silence_mult;
    logic [LW-1:0]               r_dev_floor;

    // window and tracked statistics
    logic [AW-1:0] r_wp;
    logic          r_full;
    logic [LW-1:0] r_mean;
    logic [LW-1:0] r_spread;

    // sequencer and datapath
    logic [3:0]    r_state;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_rd_idx;
    logic          r_p1;
    logic          r_p2;
    logic [SW-1:0] r_sum;
    logic [2*LW-1:0] r_sq;
    logic [QW-1:0] r_sqsum;
    logic [NW-1:0] r_nq;
    logic [NW-1:0] r_ss;
    logic [NW-1:0] r_num;
    logic [DVW-1:0] r_nn;
    logic [LW-1:0] r_mean_new;
    logic [PW-1:0] r_on_prod;
    logic [PW-1:0] r_si_prod;
    logic          r_ready_res;

    // output register
    logic                r_out_valid;
    nfst_pkg::t_out_item r_out;

    // combinational
    logic [31:0]   w_wl32;
    logic [CW-1:0] w_len;
    logic [CW-1:0] w_next_pos;
    logic          w_wrap;
    logic          w_full_new;
    logic [CW-1:0] w_pos_new;
    logic [CW-1:0] w_n_new;
    logic          w_in_acc;
    logic [LW-1:0] w_rdata;

    logic                 w_div_start;
    logic [NW-1:0]        w_div_dividend;
    logic [DVW-1:0]       w_div_divisor;
    logic [NW-1:0]        w_div_quot;
    nfst_pkg::t_unit_sts  w_div_sts;

    logic                         w_sqrt_start;
    logic [nfst_pkg::ROOT_W-1:0]  w_root;
    nfst_pkg::t_unit_sts          w_sqrt_sts;

    logic [LW-1:0]  w_dev;
    logic [TSW-1:0] w_on_sum;
    logic [TSW-1:0] w_si_sum;
    logic           w_load;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);

    // effective window length, clamped to the supported range
    assign w_wl32 = 32'(r_window_length);
    always_comb begin
        if (w_wl32 < 32'(nfst_pkg::MIN_WINDOW)) begin
            w_len = CW'(nfst_pkg::MIN_WINDOW);
        end else if (w_wl32 > 32'(HISTORY_DEPTH)) begin
            w_len = CW'(HISTORY_DEPTH);
        end else begin
            w_len = CW'(w_wl32);
        end
    end

    // write pointer advance; a shrunk length also wraps here
    assign w_next_pos = CW'(r_wp) + CW'(1);
    assign w_wrap     = w_next_pos >= w_len;
    assign w_full_new = r_full || w_wrap;
    assign w_pos_new  = w_wrap ? '0 : w_next_pos;
    assign w_n_new    = w_full_new ? w_len : w_pos_new;

    nfst_ram #(
        .WIDTH (LW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_wp),
        .i_wdata (i_in.data.chunk_level),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // shared divider: first S/n for the mean, then (n*Q - S*S)/(n*n) for the variance
    assign w_div_start    = (r_state == S_MUL) || ((r_state == S_DIVM) && w_div_sts.done);
    assign w_div_dividend = (r_state == S_MUL) ? NW'(r_sum) : r_num;
    assign w_div_divisor  = (r_state == S_MUL) ? DVW'(r_n) : r_nn;

    nfst_div #(
        .DIVIDEND_W (NW),
        .DIVISOR_W  (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_quotient (w_div_quot),
        .o_sts      (w_div_sts)
    );

    assign w_sqrt_start = (r_state == S_DIVV) && w_div_sts.done;

    nfst_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_div_quot[nfst_pkg::VAR_W-1:0]),
        .o_root     (w_root),
        .o_sts      (w_sqrt_sts)
    );

    // deviation floor clamp
    assign w_dev = (w_root < r_dev_floor) ? r_dev_floor : w_root;

    // thresholds, q4.4 product rounded down, saturated to 20 bits
    assign w_on_sum = TSW'(r_mean) + TSW'(r_on_prod >> 4);
    assign w_si_sum = TSW'(r_mean) + TSW'(r_si_prod >> 4);

    assign w_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= nfst_pkg::RST_WINDOW_LENGTH;
            r_onset_mult    <= nfst_pkg::RST_ONSET_MULTIPLIER;
            r_silence_mult  <= nfst_pkg::RST_SILENCE_MULTIPLIER;
            r_dev_floor     <= nfst_pkg::RST_DEVIATION_FLOOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nfst_pkg::REG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[nfst_pkg::WLEN_W-1:0];
                end
                nfst_pkg::REG_ONSET_MULTIPLIER: begin
                    r_onset_mult <= i_cfg_data[MW-1:0];
                end
                nfst_pkg::REG_SILENCE_MULTIPLIER: begin
                    r_silence_mult <= i_cfg_data[MW-1:0];
                end
                nfst_pkg::REG_DEVIATION_FLOOR: begin
                    r_dev_floor <= i_cfg_data[LW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer and tracked state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_mean      <= '0;
            r_spread    <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1 <= (r_state == S_SUM);
            r_p2 <= r_p1;

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_wp    <= w_pos_new[AW-1:0];
                        r_full  <= w_full_new;
                        r_state <= (w_n_new >= CW'(2)) ? S_SUM : S_THR;
                    end
                end
                S_SUM: begin
                    if (r_rd_idx == r_n - CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // wait for the read and square stages to empty
                    if (!r_p1 && !r_p2) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    if (w_div_sts.done) begin
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (w_div_sts.done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_sts.done) begin
                        r_mean   <= r_mean_new;
                        r_spread <= w_dev;
                        r_state  <= S_THR;
                    end
                end
                S_THR: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_n         <= w_n_new;
            r_rd_idx    <= '0;
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_ready_res <= w_full_new || (w_pos_new > (w_len >> 1));
        end else begin
            if (r_state == S_SUM) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            // read data arrives the cycle after its address; the square is summed the cycle after that
            if (r_p1) begin
                r_sum <= r_sum + SW'(w_rdata);
                r_sq  <= (2*LW)'(w_rdata) * (2*LW)'(w_rdata);
            end
            if (r_p2) begin
                r_sqsum <= r_sqsum + QW'(r_sq);
            end
        end

        if (r_state == S_MUL) begin
            r_nq <= NW'(r_n) * NW'(r_sqsum);
            r_ss <= NW'(r_sum) * NW'(r_sum);
            r_nn <= DVW'(r_n) * DVW'(r_n);
        end

        if (r_state == S_DIVM) begin
            r_num <= r_nq - r_ss;
            if (w_div_sts.done) begin
                r_mean_new <= w_div_quot[LW-1:0];
            end
        end

        if (r_state == S_THR) begin
            r_on_prod <= PW'(r_onset_mult) * PW'(r_spread);
            r_si_prod <= PW'(r_silence_mult) * PW'(r_spread);
        end

        if (w_load) begin
            r_out.ready_res         <= r_ready_res;
            r_out.mean_level        <= r_mean;
            r_out.deviation         <= r_spread;
            r_out.onset_threshold   <= w_on_sum[TW] ? nfst_pkg::THRESH_MAX : w_on_sum[TW-1:0];
            r_out.silence_threshold <= w_si_sum[TW] ? nfst_pkg::THRESH_MAX : w_si_sum[TW-1:0];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    // the two iterative units never overlap
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_sts.busy && w_sqrt_sts.busy))
        else $error("divider and square root busy together");

    // window sweep never reads past the current count
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_rd_idx < r_n))
        else $error("window sweep beyond entry count");

    // an accepted request always starts work
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // a result appears only from the output step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

// ----- test/nfst_stats_checker.sv -----
`timescale 1ns / 1ps

module nfst_stats_checker
    import nfst_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nfst_chan_if                  req_mon,
    nfst_chan_if                  res_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // shadow of the window and statistics
    logic [LEVEL_W-1:0] level_store [HISTORY_DEPTH];
    int unsigned        next_slot;
    logic               store_full;
    logic [LEVEL_W-1:0] mean_now;
    logic [LEVEL_W-1:0] spread_now;

    // shadow of the registers
    logic [WLEN_W-1:0]  win_len_reg;
    logic [MULT_W-1:0]  onset_k;
    logic [MULT_W-1:0]  silence_k;
    logic [LEVEL_W-1:0] spread_min;

    t_out_item expected_stats [$];
    int        fail_count;
    int        results_checked;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 results_checked, what, got, want);
        fail_count++;
    endtask

    function automatic int unsigned window_span();
        if (win_len_reg < MIN_WINDOW) return MIN_WINDOW;
        if (win_len_reg > HISTORY_DEPTH) return HISTORY_DEPTH;
        return win_len_reg;
    endfunction

    // bitwise integer square root, floored
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic [THRESH_W-1:0] sigma_threshold(input logic [MULT_W-1:0] k);
        longint unsigned t;
        t = 64'(mean_now) + ((64'(k) * 64'(spread_now)) >> 4);
        if (t > 64'(THRESH_MAX)) return THRESH_MAX;
        return THRESH_W'(t);
    endfunction

    // write one level into the window and work out the statistics it leads to
    function automatic t_out_item predict_window_stats(input logic [LEVEL_W-1:0] level);
        int unsigned     span;
        int unsigned     count;
        longint unsigned sum_x;
        longint unsigned sum_xx;
        longint unsigned spread_sq;
        longint unsigned root;
        t_out_item       r;
        span = window_span();
        if (next_slot < HISTORY_DEPTH) level_store[next_slot] = level;
        next_slot++;
        if (next_slot >= span) begin
            next_slot  = 0;
            store_full = 1'b1;
        end
        count = store_full ? span : next_slot;
        if (count >= 2) begin
            sum_x  = 0;
            sum_xx = 0;
            for (int i = 0; i < count; i++) begin
                sum_x  = sum_x + 64'(level_store[i]);
                sum_xx = sum_xx + 64'(level_store[i]) * 64'(level_store[i]);
            end
            mean_now  = LEVEL_W'(sum_x / count);
            spread_sq = (64'(count) * sum_xx - sum_x * sum_x) / (64'(count) * 64'(count));
            root      = int_sqrt(spread_sq);
            if (root < 64'(spread_min)) root = 64'(spread_min);
            if (root > 64'hFFFF) root = 64'hFFFF;
            spread_now = LEVEL_W'(root);
        end
        r.ready_res         = store_full || (next_slot > span / 2);
        r.mean_level        = mean_now;
        r.deviation         = spread_now;
        r.onset_threshold   = sigma_threshold(onset_k);
        r.silence_threshold = sigma_threshold(silence_k);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            next_slot   = 0;
            store_full  = 1'b0;
            mean_now    = '0;
            spread_now  = '0;
            win_len_reg = RST_WINDOW_LENGTH;
            onset_k     = RST_ONSET_MULTIPLIER;
            silence_k   = RST_SILENCE_MULTIPLIER;
            spread_min  = RST_DEVIATION_FLOOR;
            expected_stats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WINDOW_LENGTH:      win_len_reg = i_cfg_data[WLEN_W-1:0];
                    REG_ONSET_MULTIPLIER:   onset_k     = i_cfg_data[MULT_W-1:0];
                    REG_SILENCE_MULTIPLIER: silence_k   = i_cfg_data[MULT_W-1:0];
                    REG_DEVIATION_FLOOR:    spread_min  = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            // the result leaving now always belongs to an older request
            if (res_mon.valid && res_mon.ready) begin
                got = res_mon.data;
                if (expected_stats.size() == 0) begin
                    report_mismatch("result with no request pending", got.mean_level, 0);
                end else begin
                    want = expected_stats.pop_front();
                    if (got.ready_res !== want.ready_res)
                        report_mismatch("ready_res", got.ready_res, want.ready_res);
                    if (got.mean_level !== want.mean_level)
                        report_mismatch("mean_level", got.mean_level, want.mean_level);
                    if (got.deviation !== want.deviation)
                        report_mismatch("deviation", got.deviation, want.deviation);
                    if (got.onset_threshold !== want.onset_threshold)
                        report_mismatch("onset_threshold", got.onset_threshold,
                                        want.onset_threshold);
                    if (got.silence_threshold !== want.silence_threshold)
                        report_mismatch("silence_threshold", got.silence_threshold,
                                        want.silence_threshold);
                end
                results_checked++;
            end
            if (req_mon.valid && req_mon.ready)
                expected_stats.insert(expected_stats.size(),
                                      predict_window_stats(req_mon.data.chunk_level));
        end
        o_pending    = expected_stats.size();
        o_fail_count = fail_count;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import nfst_pkg::*;

    // no request or result for this long means the block has hung; it must outlast the
    // slowest request and the long hold-off of HOLD_CYCLES
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    // settle time after the last result, a bit above one full request
    localparam int END_SETTLE     = 400;
    localparam int RAND_PHASES    = 11;
    localparam int PHASE_ITEMS    = 122;
    // enough requests at the largest window to write every entry once
    localparam int FILL_ITEMS     = 140;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    nfst_chan_if #(.t_payload(t_in_item))  req_ch ();
    nfst_chan_if #(.t_payload(t_out_item)) res_ch ();

    int fail_count;
    int pending;

    // idling percentages for the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // hold-off handshake between the stimulus and the receiver process
    int hold_tickets = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    int quiet_cycles   = 0;
    int results_seen   = 0;
    int sent_count     = 0;
    int settings_count = 0;

    noise_floor_sigma_tracker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (req_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    nfst_stats_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .req_mon      (req_ch),
        .res_mon      (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random stalls, or a long hold-off when one is asked for
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_tickets != hold_served) begin
                hold_served = hold_tickets;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on handshake activity, plus a running count of results
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (res_ch.valid && res_ch.ready) results_seen <= results_seen + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one chunk level and wait for it to be taken; valid stays high into
    // the next request unless an idle gap is drawn
    task automatic send_level(input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.data.chunk_level <= lvl;
        do @(posedge clk); while (!req_ch.ready);
        sent_count++;
    endtask

    // stop offering and wait until every request has its result back; each
    // request gives exactly one result, so the block is idle at that point
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // write all four registers while idle; the unused upper bits of the
    // narrow registers carry random junk
    task automatic apply_settings(input logic [WLEN_W-1:0] wl, input logic [MULT_W-1:0] om,
                                  input logic [MULT_W-1:0] sm, input logic [LEVEL_W-1:0] df);
        drain_results();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_WINDOW_LENGTH;
        cfg_data <= {8'($urandom), wl};
        @(negedge clk);
        cfg_idx  <= REG_ONSET_MULTIPLIER;
        cfg_data <= {8'($urandom), om};
        @(negedge clk);
        cfg_idx  <= REG_SILENCE_MULTIPLIER;
        cfg_data <= {8'($urandom), sm};
        @(negedge clk);
        cfg_idx  <= REG_DEVIATION_FLOOR;
        cfg_data <= df;
        @(negedge clk);
        cfg_we   <= 1'b0;
        settings_count++;
    endtask

    // a run of chunk levels shaped like real audio: mostly a noise floor with
    // small jitter, some onset spikes above it, plus fully random and extreme
    // levels as noise
    task automatic run_phase(input int items);
        int unsigned floor_base;
        int unsigned noise_span;
        int unsigned kind;
        int unsigned lvl;
        floor_base = $urandom_range(0, 1) ? $urandom_range(0, 4000) : $urandom_range(0, 65535);
        noise_span = $urandom_range(0, 2000);
        repeat (items) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                lvl = floor_base + $urandom_range(0, noise_span);
            end else if (kind < 75) begin
                lvl = floor_base + $urandom_range(noise_span, 30000);
            end else if (kind < 90) begin
                lvl = $urandom_range(0, 65535);
            end else begin
                lvl = $urandom_range(0, 1) ? 65535 : 0;
            end
            send_level((lvl > 65535) ? 16'hFFFF : LEVEL_W'(lvl));
        end
    endtask

    initial begin
        logic [WLEN_W-1:0]  wl;
        logic [MULT_W-1:0]  om;
        logic [MULT_W-1:0]  sm;
        logic [LEVEL_W-1:0] df;

        rst_n                   = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.data.chunk_level = '0;
        cfg_we                  = 1'b0;
        cfg_idx                 = REG_WINDOW_LENGTH;
        cfg_data                = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: the very first request sees a single entry,
        // so mean and deviation stay zero with no floor applied
        send_level(16'h0000);
        send_level(16'hFFFF);
        send_level(16'hFFFF);
        send_level(16'h0000);
        send_level(16'h0001);
        send_level(16'hFFFE);

        // directed: length above the store depth, widest multipliers and the
        // highest floor, so both thresholds saturate
        apply_settings(8'd255, 8'd255, 8'd255, 16'hFFFF);
        send_level(16'hFFFF);
        send_level(16'hFFFF);
        send_level(16'hFFFF);
        send_level(16'd40000);
        send_level(16'hFFFF);

        // fill every store entry once at the largest window; from here on any
        // length may be chosen without reading an entry never written
        apply_settings(8'd128, 8'($urandom), 8'($urandom), 16'($urandom_range(0, 300)));
        run_phase(FILL_ITEMS);

        // directed: length below the minimum while the write position sits past
        // it, so the window shrinks mid-run and wraps; zero floor, zero onset k
        apply_settings(8'd3, 8'd0, 8'd16, 16'd0);
        send_level(16'h8000);
        send_level(16'h8000);
        send_level(16'h8000);
        send_level(16'h0000);
        send_level(16'hFFFF);

        // random phases, each with its own settings and idling pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                wl = 8'd10;
                om = 8'd255;
                sm = 8'd0;
                df = 16'd0;
            end else if (ph == 1) begin
                wl = 8'd128;
                om = 8'd0;
                sm = 8'd255;
                df = 16'hFFFF;
            end else begin
                case ($urandom_range(0, 5))
                    0:       wl = 8'($urandom_range(0, 9));
                    1:       wl = 8'd10;
                    2:       wl = 8'd128;
                    3:       wl = 8'($urandom_range(129, 255));
                    default: wl = 8'($urandom_range(10, 128));
                endcase
                case ($urandom_range(0, 3))
                    0:       om = 8'd0;
                    1:       om = 8'd255;
                    default: om = 8'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       sm = 8'd0;
                    1:       sm = 8'd255;
                    default: sm = 8'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       df = 16'd0;
                    1:       df = 16'hFFFF;
                    2:       df = 16'($urandom);
                    default: df = 16'($urandom_range(0, 400));
                endcase
            end
            apply_settings(wl, om, sm, df);

            // idling pattern rotates: none, sender, receiver, both
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 31;
                end
            endcase

            // long result hold-off while requests keep coming, to back the
            // block up until it refuses input
            if (ph == 4) hold_tickets++;

            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (END_SETTLE) @(negedge clk);

        $display("run covered %0d chunk levels under %0d register settings, %0d results",
                 sent_count, settings_count, results_seen);
        $display("idling with none, sender, receiver and both, and one long result hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
